// File: hw/rtl/ahe_pkg.sv
package ahe_pkg;

  localparam int SYMBOL_BITS_DEF = 9;
  localparam int WEIGHT_BITS_DEF = 32;
  localparam int IN_SYMBOL_W     = 9;
  localparam int CODE_W          = 64;
  localparam int CNT_W           = 7;
  localparam int MAX_CHUNKS      = 9;
  localparam int CAP_BITS        = MAX_CHUNKS * CODE_W;
  localparam int EMW             = $clog2(CAP_BITS + 1);

  // per-field write enables of the node store
  typedef struct packed {
    logic weight;
    logic symbol;
    logic left;
    logic right;
    logic parent;
  } ahe_fmask_t;

endpackage

// File: hw/rtl/adaptive_huffman_encoder.sv
// FGK adaptive Huffman encoder.
// Input: pulse start with in_symbol while busy is low; the symbol is taken at that
// edge and busy stays high until its code is out and the tree is updated.
// Output: words on out_* marked by out_valid, up to 9 words per
// symbol, out_last on the final one. The receiver cannot stall; words are
// never held back or repeated.
// Storage: the tree lives in a node RAM with one read and one write port,
// and every step is a read-modify-write of it.
// Per symbol: accept and a path walk from the coded node up to the root, plus
// the writes for a new symbol, then for each non-root node on the update path
// a search for its block leader by a linear scan (none found: no swap), the
// swap when there is a leader, and an ancestor check once the overflow flag is
// set; the root is only incremented. Then the code bits are emitted one by one
// through S_EMR and S_EMB. The last word is on the outputs in the first cycle
// that busy is low.
// After reset the symbol table is cleared, one entry a cycle, all 2^SYMBOL_BITS
// entries (512 by default), while busy stays high. The overflow flag clears on reset.
module adaptive_huffman_encoder #(
  parameter int SYMBOL_BITS = ahe_pkg::SYMBOL_BITS_DEF,
  parameter int WEIGHT_BITS = ahe_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ahe_pkg::IN_SYMBOL_W-1:0]  in_symbol,
  output logic                             out_valid,
  output logic [ahe_pkg::CODE_W-1:0]       out_code_bits,
  output logic [ahe_pkg::CNT_W-1:0]        out_bit_count,
  output logic                             out_last,
  output logic                             out_overflow
);
  import ahe_pkg::*;

  localparam int SB    = SYMBOL_BITS;
  localparam int WB    = WEIGHT_BITS;
  localparam int NSYM  = 1 << SB;
  localparam int NODES = 2 * NSYM + 1;
  localparam int SW    = SB + 2;
  localparam int SYMW  = SB + 1;
  localparam int TW    = (SW + 1 > EMW) ? SW + 1 : EMW;
  localparam logic [SYMW-1:0] MARK = {1'b1, {SB{1'b0}}};
  localparam logic [WB-1:0]   WMAX = {WB{1'b1}};

  typedef enum logic [21:0] {
    S_CLR  = 22'd1 << 0,  S_IDLE = 22'd1 << 1,  S_LOOK = 22'd1 << 2,
    S_WTGT = 22'd1 << 3,  S_WALK = 22'd1 << 4,  S_NEW0 = 22'd1 << 5,
    S_NEW1 = 22'd1 << 6,  S_NEW2 = 22'd1 << 7,  S_RDC  = 22'd1 << 8,
    S_CAP  = 22'd1 << 9,  S_SCAN = 22'd1 << 10, S_ANC  = 22'd1 << 11,
    S_ANCW = 22'd1 << 12, S_SWA  = 22'd1 << 13, S_SWB  = 22'd1 << 14,
    S_RL0  = 22'd1 << 15, S_RL1  = 22'd1 << 16, S_RL2  = 22'd1 << 17,
    S_RL3  = 22'd1 << 18, S_INC  = 22'd1 << 19, S_EMR  = 22'd1 << 20,
    S_EMB  = 22'd1 << 21
  } state_t;

  state_t state_r, state_nxt;

  logic [SB-1:0]   sym_r, sym_nxt, clr_r, clr_nxt;
  logic            known_r, known_nxt, ovf_r, ovf_nxt;
  logic [SW-1:0]   x_r, x_nxt, par_r, par_nxt, depth_r, depth_nxt;
  logic [SW-1:0]   cur_r, cur_nxt, nyt_r, nyt_nxt;
  logic [WB-1:0]   cw_r, cw_nxt, lw_r, lw_nxt;
  logic [SYMW-1:0] csym_r, csym_nxt, lsym_r, lsym_nxt;
  logic [SW-1:0]   cl_r, cl_nxt, cr_r, cr_nxt, cpar_r, cpar_nxt;
  logic [SW-1:0]   lead_r, lead_nxt, ll_r, ll_nxt, lr_r, lr_nxt, lpar_r, lpar_nxt;
  logic [SW-1:0]   scan_r, scan_nxt, pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic [SW-1:0]   anc_x_r, anc_x_nxt, anc_t_r, anc_t_nxt;
  logic            anc_ph_r, anc_ph_nxt;
  logic [EMW-1:0]  em_r, em_nxt;

  // node store ports
  logic [SW-1:0]   n_raddr;
  logic [WB-1:0]   n_weight;
  logic [SYMW-1:0] n_symbol;
  logic [SW-1:0]   n_left, n_right, n_parent;
  ahe_fmask_t      nw_mask;
  logic [SW-1:0]   nw_addr, nw_left, nw_right, nw_parent;
  logic [WB-1:0]   nw_weight;
  logic [SYMW-1:0] nw_symbol;

  // symbol table ports
  logic [SB-1:0]   s_raddr, s_waddr;
  logic            s_rvld, s_we, s_wvld;
  logic [SW-1:0]   s_rslot, s_wslot;

  // path bit buffer
  logic            path_mem [NODES];
  logic            path_we, path_wbit, path_q;
  logic [SW-1:0]   path_waddr, path_raddr;

  // bit stream to packer
  logic            b_vld, b_val, b_last;

  logic [WB-1:0]   inc_w;
  logic            sat;
  logic [SW:0]     nyt_p2;
  logic [TW-1:0]   tot_full, k_sh;
  logic [EMW-1:0]  total;
  logic [SB-1:0]   sym_sh;
  logic            scan_issue, scan_match;
  logic [SW-1:0]   x_sel;

  assign sat      = (cw_r == WMAX);
  assign inc_w    = sat ? cw_r : cw_r + WB'(1);
  assign nyt_p2   = {1'b0, nyt_r} + (SW+1)'(2);
  assign tot_full = TW'(depth_r) + (known_r ? TW'(0) : TW'(SB));
  assign total    = (tot_full > TW'(CAP_BITS)) ? EMW'(CAP_BITS) : EMW'(tot_full);
  assign k_sh     = TW'(em_r) - TW'(depth_r);
  assign sym_sh   = sym_r << k_sh;
  assign scan_issue = (scan_r < cur_r);
  assign scan_match = pend_vld_r && (n_weight == cw_r) && (pend_r != cpar_r);
  assign x_sel    = s_rvld ? s_rslot : nyt_r;

  always_comb begin
    state_nxt    = state_r;
    sym_nxt      = sym_r;
    clr_nxt      = clr_r;
    known_nxt    = known_r;
    ovf_nxt      = ovf_r;
    x_nxt        = x_r;
    par_nxt      = par_r;
    depth_nxt    = depth_r;
    cur_nxt      = cur_r;
    nyt_nxt      = nyt_r;
    cw_nxt       = cw_r;
    csym_nxt     = csym_r;
    cl_nxt       = cl_r;
    cr_nxt       = cr_r;
    cpar_nxt     = cpar_r;
    lead_nxt     = lead_r;
    lw_nxt       = lw_r;
    lsym_nxt     = lsym_r;
    ll_nxt       = ll_r;
    lr_nxt       = lr_r;
    lpar_nxt     = lpar_r;
    scan_nxt     = scan_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    anc_x_nxt    = anc_x_r;
    anc_t_nxt    = anc_t_r;
    anc_ph_nxt   = anc_ph_r;
    em_nxt       = em_r;

    n_raddr   = cur_r;
    nw_mask   = '0;
    nw_addr   = cur_r;
    nw_weight = inc_w;
    nw_symbol = MARK;
    nw_left   = cl_r;
    nw_right  = cr_r;
    nw_parent = nyt_r;
    s_raddr   = SB'(in_symbol);
    s_we      = 1'b0;
    s_waddr   = sym_r;
    s_wvld    = 1'b1;
    s_wslot   = lead_r;
    path_we    = 1'b0;
    path_waddr = depth_r;
    path_wbit  = (n_right == x_r);
    path_raddr = SW'(TW'(depth_r) - TW'(em_r) - TW'(1));
    b_vld  = 1'b0;
    b_val  = (TW'(em_r) < TW'(depth_r)) ? path_q : sym_sh[SB-1];
    b_last = ((em_r + EMW'(1)) == total);

    unique case (state_r)
      S_CLR: begin
        s_we      = 1'b1;
        s_waddr   = clr_r;
        s_wvld    = 1'b0;
        nw_mask   = '{weight: 1'b1, symbol: 1'b1, default: 1'b0};
        nw_addr   = '0;
        nw_weight = '0;
        clr_nxt   = clr_r + SB'(1);
        if (clr_r == SB'(NSYM - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          sym_nxt   = SB'(in_symbol);
          em_nxt    = '0;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        known_nxt = s_rvld;
        x_nxt     = x_sel;
        cur_nxt   = x_sel;
        depth_nxt = '0;
        n_raddr   = x_sel;
        state_nxt = S_WTGT;
      end
      S_WTGT, S_WALK: begin
        if (state_r == S_WALK) begin
          path_we   = 1'b1;
          depth_nxt = depth_r + SW'(1);
          x_nxt     = par_r;
        end
        par_nxt = n_parent;
        n_raddr = n_parent;
        if ((state_r == S_WTGT && x_r == '0) || (state_r == S_WALK && par_r == '0)) begin
          if (known_r) state_nxt = S_RDC;
          else if (nyt_p2 < (SW+1)'(NODES)) state_nxt = S_NEW0;
          else state_nxt = S_EMR;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_NEW0: begin
        nw_mask  = '{symbol: 1'b1, left: 1'b1, right: 1'b1, default: 1'b0};
        nw_addr  = nyt_r;
        nw_left  = SW'(nyt_p2);
        nw_right = nyt_r + SW'(1);
        s_we     = 1'b1;
        s_wslot  = nyt_r + SW'(1);
        state_nxt = S_NEW1;
      end
      S_NEW1: begin
        nw_mask   = '{weight: 1'b1, symbol: 1'b1, parent: 1'b1, default: 1'b0};
        nw_addr   = nyt_r + SW'(1);
        nw_weight = '0;
        nw_symbol = {1'b0, sym_r};
        state_nxt = S_NEW2;
      end
      S_NEW2: begin
        nw_mask   = '{weight: 1'b1, symbol: 1'b1, parent: 1'b1, default: 1'b0};
        nw_addr   = SW'(nyt_p2);
        nw_weight = '0;
        nyt_nxt   = SW'(nyt_p2);
        cur_nxt   = nyt_r + SW'(1);
        state_nxt = S_RDC;
      end
      S_RDC: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cw_nxt       = n_weight;
        csym_nxt     = n_symbol;
        cl_nxt       = n_left;
        cr_nxt       = n_right;
        cpar_nxt     = n_parent;
        scan_nxt     = '0;
        pend_vld_nxt = 1'b0;
        state_nxt    = (cur_r == '0) ? S_INC : S_SCAN;
      end
      S_SCAN: begin
        n_raddr = scan_r;
        if (scan_match) begin
          lead_nxt = pend_r;
          lw_nxt   = n_weight;
          lsym_nxt = n_symbol;
          ll_nxt   = n_left;
          lr_nxt   = n_right;
          lpar_nxt = n_parent;
          anc_x_nxt  = cpar_r;
          anc_t_nxt  = pend_r;
          anc_ph_nxt = 1'b0;
          if (pend_r == '0) state_nxt = S_INC;
          else if (ovf_r) state_nxt = S_ANC;
          else state_nxt = S_SWA;
        end else if (!pend_vld_r && !scan_issue) begin
          state_nxt = S_INC;
        end else begin
          pend_vld_nxt = scan_issue;
          pend_nxt     = scan_r;
          scan_nxt     = scan_r + SW'(scan_issue);
        end
      end
      S_ANC: begin
        n_raddr = anc_x_r;
        if (anc_x_r == anc_t_r) begin
          state_nxt = S_INC;
        end else if (anc_x_r == '0) begin
          if (anc_ph_r) begin
            state_nxt = S_SWA;
          end else begin
            anc_x_nxt  = lpar_r;
            anc_t_nxt  = cur_r;
            anc_ph_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_ANCW;
        end
      end
      S_ANCW: begin
        anc_x_nxt = n_parent;
        state_nxt = S_ANC;
      end
      S_SWA: begin
        nw_mask   = '{weight: 1'b1, symbol: 1'b1, left: 1'b1, right: 1'b1,
                      default: 1'b0};
        nw_addr   = lead_r;
        nw_symbol = csym_r;
        if (sat) ovf_nxt = 1'b1;
        if (nyt_r == lead_r) nyt_nxt = cur_r;
        else if (nyt_r == cur_r) nyt_nxt = lead_r;
        s_we      = !csym_r[SB];
        s_waddr   = csym_r[SB-1:0];
        s_wslot   = lead_r;
        state_nxt = S_SWB;
      end
      S_SWB: begin
        nw_mask   = '{weight: 1'b1, symbol: 1'b1, left: 1'b1, right: 1'b1,
                      default: 1'b0};
        nw_weight = lw_r;
        nw_symbol = lsym_r;
        nw_left   = ll_r;
        nw_right  = lr_r;
        s_we      = !lsym_r[SB];
        s_waddr   = lsym_r[SB-1:0];
        s_wslot   = cur_r;
        state_nxt = S_RL0;
      end
      S_RL0, S_RL1: begin
        nw_mask.parent = (csym_r == MARK) && (lead_r != nyt_r);
        nw_addr   = (state_r == S_RL0) ? cl_r : cr_r;
        nw_parent = lead_r;
        state_nxt = (state_r == S_RL0) ? S_RL1 : S_RL2;
      end
      S_RL2, S_RL3: begin
        nw_mask.parent = (lsym_r == MARK) && (cur_r != nyt_r);
        nw_addr   = (state_r == S_RL2) ? ll_r : lr_r;
        nw_parent = cur_r;
        if (state_r == S_RL2) begin
          state_nxt = S_RL3;
        end else begin
          cur_nxt   = lpar_r;
          state_nxt = S_RDC;
        end
      end
      S_INC: begin
        nw_mask.weight = 1'b1;
        if (sat) ovf_nxt = 1'b1;
        if (cur_r == '0) begin
          state_nxt = S_EMR;
        end else begin
          cur_nxt   = cpar_r;
          state_nxt = S_RDC;
        end
      end
      S_EMR: begin
        state_nxt = S_EMB;
      end
      S_EMB: begin
        b_vld  = 1'b1;
        em_nxt = em_r + EMW'(1);
        state_nxt = b_last ? S_IDLE : S_EMR;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      nyt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      nyt_r   <= nyt_nxt;
      ovf_r   <= ovf_nxt;
    end
    sym_r      <= sym_nxt;
    known_r    <= known_nxt;
    x_r        <= x_nxt;
    par_r      <= par_nxt;
    depth_r    <= depth_nxt;
    cur_r      <= cur_nxt;
    cw_r       <= cw_nxt;
    csym_r     <= csym_nxt;
    cl_r       <= cl_nxt;
    cr_r       <= cr_nxt;
    cpar_r     <= cpar_nxt;
    lead_r     <= lead_nxt;
    lw_r       <= lw_nxt;
    lsym_r     <= lsym_nxt;
    ll_r       <= ll_nxt;
    lr_r       <= lr_nxt;
    lpar_r     <= lpar_nxt;
    scan_r     <= scan_nxt;
    pend_r     <= pend_nxt;
    pend_vld_r <= pend_vld_nxt;
    anc_x_r    <= anc_x_nxt;
    anc_t_r    <= anc_t_nxt;
    anc_ph_r   <= anc_ph_nxt;
    em_r       <= em_nxt;
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= path_wbit;
    path_q <= path_mem[path_raddr];
  end

  assign busy = (state_r != S_IDLE);

  ahe_node_mem #(.SW(SW), .WB(WB), .SYMW(SYMW), .DEPTH(NODES)) u_node (
    .clk       (clk),
    .rd_addr   (n_raddr),
    .rd_weight (n_weight),
    .rd_symbol (n_symbol),
    .rd_left   (n_left),
    .rd_right  (n_right),
    .rd_parent (n_parent),
    .wr_mask   (nw_mask),
    .wr_addr   (nw_addr),
    .wr_weight (nw_weight),
    .wr_symbol (nw_symbol),
    .wr_left   (nw_left),
    .wr_right  (nw_right),
    .wr_parent (nw_parent)
  );

  ahe_slot_mem #(.SB(SB), .SW(SW)) u_slot (
    .clk     (clk),
    .rd_addr (s_raddr),
    .rd_vld  (s_rvld),
    .rd_slot (s_rslot),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_vld  (s_wvld),
    .wr_slot (s_wslot)
  );

  ahe_packer u_pack (
    .clk           (clk),
    .rst_n         (rst_n),
    .bit_vld       (b_vld),
    .bit_val       (b_val),
    .bit_last      (b_last),
    .ovf           (ovf_r),
    .out_valid     (out_valid),
    .out_code_bits (out_code_bits),
    .out_bit_count (out_bit_count),
    .out_last      (out_last),
    .out_overflow  (out_overflow)
  );

  a_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_bit_count == CNT_W'(CODE_W))
    else $error("non-final word not full");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted symbol did not raise busy");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag dropped");

  a_nyt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, nyt_r} < (SW+1)'(NODES))
    else $error("NYT slot out of range");

endmodule

// File: hw/rtl/ahe_node_mem.sv
module ahe_node_mem #(
  parameter int SW    = ahe_pkg::SYMBOL_BITS_DEF + 2,
  parameter int WB    = ahe_pkg::WEIGHT_BITS_DEF,
  parameter int SYMW  = ahe_pkg::SYMBOL_BITS_DEF + 1,
  parameter int DEPTH = 2 * (1 << ahe_pkg::SYMBOL_BITS_DEF) + 1
) (
  input  logic                 clk,
  input  logic [SW-1:0]        rd_addr,
  output logic [WB-1:0]        rd_weight,
  output logic [SYMW-1:0]      rd_symbol,
  output logic [SW-1:0]        rd_left,
  output logic [SW-1:0]        rd_right,
  output logic [SW-1:0]        rd_parent,
  input  ahe_pkg::ahe_fmask_t  wr_mask,
  input  logic [SW-1:0]        wr_addr,
  input  logic [WB-1:0]        wr_weight,
  input  logic [SYMW-1:0]      wr_symbol,
  input  logic [SW-1:0]        wr_left,
  input  logic [SW-1:0]        wr_right,
  input  logic [SW-1:0]        wr_parent
);
  import ahe_pkg::*;

  logic [WB-1:0]   weight_mem [DEPTH];
  logic [SYMW-1:0] symbol_mem [DEPTH];
  logic [SW-1:0]   left_mem   [DEPTH];
  logic [SW-1:0]   right_mem  [DEPTH];
  logic [SW-1:0]   parent_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_mask.weight) weight_mem[wr_addr] <= wr_weight;
    if (wr_mask.symbol) symbol_mem[wr_addr] <= wr_symbol;
    if (wr_mask.left)   left_mem[wr_addr]   <= wr_left;
    if (wr_mask.right)  right_mem[wr_addr]  <= wr_right;
    if (wr_mask.parent) parent_mem[wr_addr] <= wr_parent;
    rd_weight <= weight_mem[rd_addr];
    rd_symbol <= symbol_mem[rd_addr];
    rd_left   <= left_mem[rd_addr];
    rd_right  <= right_mem[rd_addr];
    rd_parent <= parent_mem[rd_addr];
  end

endmodule

// File: hw/rtl/ahe_slot_mem.sv
module ahe_slot_mem #(
  parameter int SB = ahe_pkg::SYMBOL_BITS_DEF,
  parameter int SW = ahe_pkg::SYMBOL_BITS_DEF + 2
) (
  input  logic          clk,
  input  logic [SB-1:0] rd_addr,
  output logic          rd_vld,
  output logic [SW-1:0] rd_slot,
  input  logic          wr_en,
  input  logic [SB-1:0] wr_addr,
  input  logic          wr_vld,
  input  logic [SW-1:0] wr_slot
);
  import ahe_pkg::*;

  localparam int NSYM = 1 << SB;

  logic [SW:0] slot_mem [NSYM];

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= {wr_vld, wr_slot};
    {rd_vld, rd_slot} <= slot_mem[rd_addr];
  end

endmodule

// File: hw/rtl/ahe_packer.sv
module ahe_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        bit_vld,
  input  logic                        bit_val,
  input  logic                        bit_last,
  input  logic                        ovf,
  output logic                        out_valid,
  output logic [ahe_pkg::CODE_W-1:0]  out_code_bits,
  output logic [ahe_pkg::CNT_W-1:0]   out_bit_count,
  output logic                        out_last,
  output logic                        out_overflow
);
  import ahe_pkg::*;

  logic [CODE_W-1:0] sh_r, sh_nxt, acc;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, acnt;
  logic              vld_r, vld_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CNT_W-1:0]  bc_r, bc_nxt;
  logic              last_r, last_nxt;
  logic              ovf_r, ovf_nxt;

  always_comb begin
    acc      = {sh_r[CODE_W-2:0], bit_val};
    acnt     = cnt_r + CNT_W'(1);
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    vld_nxt  = 1'b0;
    code_nxt = code_r;
    bc_nxt   = bc_r;
    last_nxt = last_r;
    ovf_nxt  = ovf_r;
    if (bit_vld) begin
      if (acnt == CNT_W'(CODE_W) || bit_last) begin
        vld_nxt  = 1'b1;
        code_nxt = acc;
        bc_nxt   = acnt;
        last_nxt = bit_last;
        ovf_nxt  = ovf;
        sh_nxt   = '0;
        cnt_nxt  = '0;
      end else begin
        sh_nxt  = acc;
        cnt_nxt = acnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_r  <= '0;
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      sh_r  <= sh_nxt;
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
    code_r <= code_nxt;
    bc_r   <= bc_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid     = vld_r;
  assign out_code_bits = code_r;
  assign out_bit_count = bc_r;
  assign out_last      = last_r;
  assign out_overflow  = ovf_r;

endmodule

// File: verif/adaptive_huffman_encoder_tb.sv
`timescale 1ns / 1ps

module adaptive_huffman_encoder_tb;
  import ahe_pkg::*;

  localparam int NSYM     = 1 << SYMBOL_BITS_DEF;
  localparam int NODES    = 2 * NSYM + 1;
  localparam int INTERNAL = NSYM;
  localparam longint unsigned WMAX = (64'd1 << WEIGHT_BITS_DEF) - 1;
  localparam int N_DIRECTED = 18;
  localparam int N_RANDOM   = 202;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  cnt;
    logic              last;
    logic              ovf;
  } code_word_t;

  typedef struct {
    logic [IN_SYMBOL_W-1:0] sym;
    bit                     typed;
    logic [CODE_W-1:0]      code;
    logic [CNT_W-1:0]       cnt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [IN_SYMBOL_W-1:0] in_symbol = '0;
  logic busy;
  logic out_valid;
  logic [CODE_W-1:0] out_code_bits;
  logic [CNT_W-1:0] out_bit_count;
  logic out_last;
  logic out_overflow;

  adaptive_huffman_encoder DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_symbol(in_symbol),
    .out_valid(out_valid), .out_code_bits(out_code_bits),
    .out_bit_count(out_bit_count), .out_last(out_last), .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  // shadow tree
  longint unsigned t_weight[NODES];
  int unsigned t_parent[NODES];
  int unsigned t_left[NODES];
  int unsigned t_right[NODES];
  int unsigned t_symbol[NODES];
  int unsigned sym_slot[NSYM];
  bit sym_seen[NSYM];
  int unsigned nyt;
  bit ovf_flag;

  code_word_t pending_words[$];
  code_word_t scratch_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  logic [IN_SYMBOL_W-1:0] alphabet[24];

  function automatic void tree_reset();
    for (int i = 0; i < NODES; i++) begin
      t_weight[i] = 0; t_parent[i] = 0; t_left[i] = 0; t_right[i] = 0; t_symbol[i] = 0;
    end
    for (int i = 0; i < NSYM; i++) begin
      sym_slot[i] = 0; sym_seen[i] = 0;
    end
    t_symbol[0] = INTERNAL;
    nyt = 0;
    ovf_flag = 0;
  endfunction

  function automatic bit above(int unsigned anc, int unsigned x);
    int unsigned cur;
    int g;
    cur = x;
    g = 0;
    while (cur != 0 && cur < NODES && g < NODES) begin
      cur = t_parent[cur];
      if (cur == anc) return 1;
      g++;
    end
    return 0;
  endfunction

  function automatic void relink(int unsigned s);
    if (t_symbol[s] == INTERNAL && s != nyt) begin
      if (t_left[s] < NODES) t_parent[t_left[s]] = s;
      if (t_right[s] < NODES) t_parent[t_right[s]] = s;
    end else if (t_symbol[s] < NSYM) begin
      sym_slot[t_symbol[s]] = s;
    end
  endfunction

  function automatic void exchange(int unsigned a, int unsigned b);
    longint unsigned w;
    int unsigned t;
    w = t_weight[a]; t_weight[a] = t_weight[b]; t_weight[b] = w;
    t = t_symbol[a]; t_symbol[a] = t_symbol[b]; t_symbol[b] = t;
    t = t_left[a]; t_left[a] = t_left[b]; t_left[b] = t;
    t = t_right[a]; t_right[a] = t_right[b]; t_right[b] = t;
    if (nyt == a) nyt = b;
    else if (nyt == b) nyt = a;
    relink(a);
    relink(b);
  endfunction

  function automatic void bump_path(int unsigned first);
    int unsigned cur;
    int unsigned ldr;
    int g;
    cur = first;
    g = 0;
    while (cur < NODES && g < NODES) begin
      ldr = cur;
      for (int unsigned s = 0; s < cur; s++) begin
        if (t_weight[s] == t_weight[cur] && s != t_parent[cur]) begin
          ldr = s;
          break;
        end
      end
      if (ldr != cur && ldr != 0 && !above(ldr, cur) && !above(cur, ldr)) begin
        exchange(ldr, cur);
        cur = ldr;
      end
      if (t_weight[cur] >= WMAX) begin
        t_weight[cur] = WMAX;
        ovf_flag = 1;
      end else begin
        t_weight[cur]++;
      end
      if (cur == 0) break;
      cur = t_parent[cur];
      g++;
    end
  endfunction

  function automatic void encode_symbol(logic [IN_SYMBOL_W-1:0] raw,
                                        ref code_word_t dst[$]);
    int unsigned sym, tgt, cur, p, depth, total, pos, n, chunks, lf, ny;
    int g;
    bit known;
    bit path[NODES];
    bit bits[CAP_BITS];
    code_word_t w;
    sym = raw & (NSYM - 1);
    known = sym_seen[sym];
    tgt = known ? sym_slot[sym] : nyt;
    depth = 0; total = 0; g = 0;
    cur = tgt;
    while (cur != 0 && cur < NODES && g < NODES) begin
      p = t_parent[cur];
      if (p >= NODES) break;
      path[depth++] = (t_right[p] == cur);
      cur = p;
      g++;
    end
    for (int i = 0; i < depth && total < CAP_BITS; i++) bits[total++] = path[depth-1-i];
    if (!known)
      for (int i = 0; i < SYMBOL_BITS_DEF && total < CAP_BITS; i++)
        bits[total++] = 1'((sym >> (SYMBOL_BITS_DEF - 1 - i)) & 1);
    if (!known) begin
      if (nyt + 2 < NODES) begin
        lf = nyt + 1; ny = nyt + 2;
        t_left[nyt] = ny; t_right[nyt] = lf; t_symbol[nyt] = INTERNAL;
        t_weight[lf] = 0; t_parent[lf] = nyt; t_symbol[lf] = sym;
        t_weight[ny] = 0; t_parent[ny] = nyt; t_symbol[ny] = INTERNAL;
        nyt = ny;
        sym_slot[sym] = lf;
        sym_seen[sym] = 1;
        bump_path(lf);
      end
    end else begin
      bump_path(tgt);
    end
    pos = 0; chunks = 0;
    while (pos < total && chunks < MAX_CHUNKS) begin
      n = total - pos;
      if (n > CODE_W) n = CODE_W;
      w.code = '0;
      for (int i = 0; i < n; i++) w.code = {w.code[CODE_W-2:0], bits[pos+i]};
      pos += n;
      w.cnt = CNT_W'(n);
      w.last = (pos >= total);
      w.ovf = ovf_flag;
      dst.push_back(w);
      chunks++;
    end
  endfunction

  task automatic send_symbol(logic [IN_SYMBOL_W-1:0] sym, bit typed,
                             logic [CODE_W-1:0] code, logic [CNT_W-1:0] cnt);
    code_word_t w;
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (busy);
    if (typed) begin
      scratch_words.delete();
      encode_symbol(sym, scratch_words);
      w.code = code; w.cnt = cnt; w.last = 1'b1; w.ovf = 1'b0;
      pending_words.push_back(w);
    end else begin
      encode_symbol(sym, pending_words);
    end
    items_sent++;
    // bursts: mostly back to back, sometimes a gap
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    code_word_t e;
    if (rst_n && out_valid) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected word code_bits=%h", out_code_bits);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_code_bits !== e.code) begin
          $error("code_bits exp %h got %h", e.code, out_code_bits); errors++;
        end
        if (out_bit_count !== e.cnt) begin
          $error("bit_count exp %0d got %0d", e.cnt, out_bit_count); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, out_overflow); errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    dir_row_t rows[N_DIRECTED];
    int wait_cnt;
    rows = '{
      '{9'd0,   1'b1, 64'h0,   7'd9},
      '{9'd511, 1'b1, 64'h1FF, 7'd10},
      '{9'd0,   1'b0, 64'h0, 7'd0},
      '{9'd511, 1'b0, 64'h0, 7'd0},
      '{9'd511, 1'b0, 64'h0, 7'd0},
      '{9'd256, 1'b0, 64'h0, 7'd0},
      '{9'd1,   1'b0, 64'h0, 7'd0},
      '{9'h155, 1'b0, 64'h0, 7'd0},
      '{9'h0AA, 1'b0, 64'h0, 7'd0},
      '{9'd0,   1'b0, 64'h0, 7'd0},
      '{9'd0,   1'b0, 64'h0, 7'd0},
      '{9'd0,   1'b0, 64'h0, 7'd0},
      '{9'd256, 1'b0, 64'h0, 7'd0},
      '{9'd1,   1'b0, 64'h0, 7'd0},
      '{9'h155, 1'b0, 64'h0, 7'd0},
      '{9'd511, 1'b0, 64'h0, 7'd0},
      '{9'h0AA, 1'b0, 64'h0, 7'd0},
      '{9'd255, 1'b0, 64'h0, 7'd0}
    };
    tree_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_symbol(rows[i].sym, rows[i].typed, rows[i].code, rows[i].cnt);
    foreach (alphabet[i]) alphabet[i] = IN_SYMBOL_W'($urandom_range(0, NSYM - 1));
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_symbol(alphabet[$urandom_range(0, 23)], 1'b0, '0, '0);
      else
        send_symbol(IN_SYMBOL_W'($urandom_range(0, NSYM - 1)), 1'b0, '0, '0);
    end
    @(negedge clk);
    start <= 1'b0;
    wait_cnt = 0;
    while ((pending_words.size() != 0 || busy) && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d words never arrived", pending_words.size());
      errors++;
    end
    $display("Encoded %0d symbols (%0d distinct in shadow tree), checked %0d code words",
             items_sent, nyt / 2, words_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
